@@ rtl/bfha_pkg.sv @@
// Shared types and constants for the best-fit heap allocator.
// Used by the block table, the sequencer and the top level.
package bfha_pkg;

    localparam int ARENA_BYTES       = 1048576;
    localparam int MAX_BLOCKS        = 64;
    localparam int HEADER_BYTES      = 24;
    localparam int POOL_HEADER_BYTES = 24;
    localparam int ALIGN_BYTES       = 8;
    localparam int MIN_SPLIT_BYTES   = 16;

    localparam int OFF_W  = 20;
    localparam int REQ_W  = 32;
    localparam int SZ_W   = REQ_W + 1;
    localparam int CNT_W  = 21;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int IN_W   = 56;
    localparam int OUT_W  = 48;

    typedef logic [OFF_W-1:0] off_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [SZ_W-1:0]  size_t;

    typedef struct packed {
        off_t start;
        off_t size;
        logic free;
        idx_t link;
    } entry_t;

    localparam entry_t RESET_ENTRY = '{
        start: OFF_W'(POOL_HEADER_BYTES),
        size:  OFF_W'(ARENA_BYTES - POOL_HEADER_BYTES - HEADER_BYTES),
        free:  1'b1,
        link:  '0
    };

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_RESIZE  = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_NOMEM   = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FND_CHK,
        S_ALC_CHK,
        S_SPL_NEW,
        S_SPL_OLD,
        S_REL_WR,
        S_MRG_RD0,
        S_MRG_LD0,
        S_MRG_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic   rd_en;
        idx_t   rd_idx;
        logic   wr_en;
        idx_t   wr_idx;
        entry_t wr_data;
        logic   set_en;
        idx_t   set_idx;
        logic   clr_en;
        idx_t   clr_idx;
    } tbl_cmd_t;

    typedef struct packed {
        entry_t rd_data;
        logic   rd_valid;
        logic   spare_found;
        idx_t   spare_idx;
    } tbl_rsp_t;

    typedef struct packed {
        logic    done;
        off_t    res_off;
        status_t status;
        cnt_t    in_use;
    } seq_out_t;

endpackage

@@ rtl/bfha_table.sv @@
// Block table: one memory of block records with a registered read port,
// valid flags in flip-flops and a search for a spare entry. Uses bfha_pkg.
module bfha_table
    import bfha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tbl_cmd_t cmd,
    output tbl_rsp_t rsp
);

    entry_t                mem [MAX_BLOCKS];
    entry_t                rd_data_reg;
    logic                  rd_zero_reg;
    logic                  rd_valid_reg;
    logic                  init_reg;
    logic [MAX_BLOCKS-1:0] valid_reg;
    logic                  spare_found;
    idx_t                  spare_idx;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_idx] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= MAX_BLOCKS'(1);
            init_reg     <= 1'b0;
            rd_zero_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_en)
            begin
                valid_reg[cmd.set_idx] <= 1'b1;
            end
            if (cmd.clr_en)
            begin
                valid_reg[cmd.clr_idx] <= 1'b0;
            end
            if (cmd.wr_en && cmd.wr_idx == '0)
            begin
                init_reg <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_zero_reg  <= (cmd.rd_idx == '0) && !init_reg;
                rd_valid_reg <= valid_reg[cmd.rd_idx];
            end
        end
    end

    always_comb
    begin
        spare_found = 1'b0;
        spare_idx   = '0;
        for (int i = MAX_BLOCKS - 1; i >= 1; i--)
        begin
            if (!valid_reg[i])
            begin
                spare_found = 1'b1;
                spare_idx   = IDX_W'(i);
            end
        end
    end

    assign rsp.rd_data     = rd_zero_reg ? RESET_ENTRY : rd_data_reg;
    assign rsp.rd_valid    = rd_valid_reg;
    assign rsp.spare_found = spare_found;
    assign rsp.spare_idx   = spare_idx;

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n) valid_reg[0])
        else $error("Head entry lost its valid flag.");
    a_set_spare: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_en |-> !valid_reg[cmd.set_idx] && cmd.set_idx != '0)
        else $error("Split claimed an entry that is already valid.");
    a_clr_head: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_en |-> cmd.clr_idx != '0 && valid_reg[cmd.clr_idx])
        else $error("Merge released the head or an invalid entry.");

endmodule

@@ rtl/bfha_seq.sv @@
// Sequencer for allocate, release and resize: walks the block list one
// table read per cycle and keeps the in-use count. Uses bfha_pkg.
module bfha_seq
    import bfha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  op_t      in_op,
    input  logic [REQ_W-1:0] in_req,
    input  off_t     in_off,
    input  logic     out_free,
    output seq_out_t result,
    output tbl_cmd_t cmd,
    input  tbl_rsp_t rsp
);

    localparam int MIN_REM = HEADER_BYTES + MIN_SPLIT_BYTES;

    state_t  state_reg, state_next;
    op_t     op_reg, op_next;
    size_t   size_reg, size_next;
    logic    req_zero_reg, req_zero_next;
    off_t    off_reg, off_next;
    idx_t    fidx_reg, fidx_next;
    entry_t  frec_reg, frec_next;
    idx_t    cur_idx_reg, cur_idx_next;
    entry_t  cur_rec_reg, cur_rec_next;
    idx_t    nx_idx_reg, nx_idx_next;
    logic    best_valid_reg, best_valid_next;
    idx_t    best_idx_reg, best_idx_next;
    entry_t  best_rec_reg, best_rec_next;
    idx_t    tgt_idx_reg, tgt_idx_next;
    entry_t  tgt_rec_reg, tgt_rec_next;
    logic    alloc_reg, alloc_next;
    logic    grow_reg, grow_next;
    logic    split_reg, split_next;
    cnt_t    cnt_reg, cnt_next;
    off_t    res_reg, res_next;
    status_t status_reg, status_next;

    entry_t  d;
    size_t   in_size;
    logic    find_match;
    logic    fit;
    logic    exact;
    logic    walk_end;
    logic    have_best;
    idx_t    pick_idx;
    entry_t  pick_rec;
    off_t    nsize;
    off_t    rem;
    logic    do_split;
    logic    adjacent;
    logic    do_merge;
    logic    find_last;
    logic [CNT_W:0] cnt_sum;
    off_t    sub_val;
    cnt_t    cnt_less;

    assign d          = rsp.rd_data;
    assign in_size    = (SZ_W'(in_req) + SZ_W'(ALIGN_BYTES - 1)) & ~SZ_W'(ALIGN_BYTES - 1);
    assign find_match = rsp.rd_valid && !d.free &&
                        ((CNT_W'(d.start) + CNT_W'(HEADER_BYTES)) == CNT_W'(off_reg));
    assign find_last  = (cur_idx_reg == IDX_W'(MAX_BLOCKS - 1));
    assign fit        = d.free && (SZ_W'(d.size) >= size_reg) &&
                        (!best_valid_reg || d.size < best_rec_reg.size);
    assign exact      = fit && (SZ_W'(d.size) == size_reg);
    assign walk_end   = exact || (d.link == '0);
    assign have_best  = fit || best_valid_reg;
    assign pick_idx   = fit ? cur_idx_reg : best_idx_reg;
    assign pick_rec   = fit ? d : best_rec_reg;
    assign nsize      = size_reg[OFF_W-1:0];
    assign rem        = tgt_rec_reg.size - nsize;
    assign do_split   = (rem >= OFF_W'(MIN_REM)) && rsp.spare_found;
    assign adjacent   = (CNT_W'(cur_rec_reg.start) + CNT_W'(HEADER_BYTES) +
                         CNT_W'(cur_rec_reg.size)) == CNT_W'(d.start);
    assign do_merge   = cur_rec_reg.free && d.free && adjacent;
    assign cnt_sum    = (CNT_W+1)'(cnt_reg) + (CNT_W+1)'(nsize);

    always_comb
    begin
        case (state_reg)
            S_SPL_OLD: sub_val = frec_reg.size - nsize;
            default:   sub_val = frec_reg.size;
        endcase
        cnt_less = (CNT_W'(sub_val) >= cnt_reg) ? '0 : cnt_reg - CNT_W'(sub_val);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_op)
                        OP_ALLOC:   state_next = (in_req == '0) ? S_DONE : S_ALC_CHK;
                        OP_RELEASE: state_next = (in_off == '0) ? S_DONE : S_FND_CHK;
                        OP_RESIZE:
                        begin
                            if (in_off != '0)
                            begin
                                state_next = S_FND_CHK;
                            end
                            else
                            begin
                                state_next = (in_req == '0) ? S_DONE : S_ALC_CHK;
                            end
                        end
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_FND_CHK:
            begin
                if (find_match)
                begin
                    if (op_reg == OP_RELEASE || req_zero_reg)
                    begin
                        state_next = S_REL_WR;
                    end
                    else if (size_reg <= SZ_W'(d.size))
                    begin
                        state_next = S_SPL_NEW;
                    end
                    else
                    begin
                        state_next = S_ALC_CHK;
                    end
                end
                else if (find_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_ALC_CHK:
            begin
                if (walk_end)
                begin
                    state_next = have_best ? S_SPL_NEW : S_DONE;
                end
            end
            S_SPL_NEW: state_next = S_SPL_OLD;
            S_SPL_OLD: state_next = (alloc_reg && grow_reg) ? S_REL_WR : S_DONE;
            S_REL_WR:  state_next = S_MRG_RD0;
            S_MRG_RD0: state_next = S_MRG_LD0;
            S_MRG_LD0: state_next = (d.link == '0) ? S_DONE : S_MRG_CHK;
            S_MRG_CHK: state_next = (d.link == '0) ? S_DONE : S_MRG_CHK;
            S_DONE:    state_next = out_free ? S_IDLE : S_DONE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        in_ready     = 1'b0;
        result.done  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.rd_en  = in_valid;
                cmd.rd_idx = '0;
            end
            S_FND_CHK:
            begin
                cmd.rd_en  = !find_match && !find_last;
                cmd.rd_idx = find_match ? idx_t'(0) : cur_idx_reg + idx_t'(1);
                if (find_match && op_reg == OP_RESIZE && !req_zero_reg &&
                    size_reg > SZ_W'(d.size))
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            S_ALC_CHK:
            begin
                cmd.rd_en  = !walk_end;
                cmd.rd_idx = d.link;
            end
            S_SPL_NEW:
            begin
                cmd.wr_en         = do_split;
                cmd.wr_idx        = rsp.spare_idx;
                cmd.wr_data.start = tgt_rec_reg.start + OFF_W'(HEADER_BYTES) + nsize;
                cmd.wr_data.size  = rem - OFF_W'(HEADER_BYTES);
                cmd.wr_data.free  = 1'b1;
                cmd.wr_data.link  = tgt_rec_reg.link;
                cmd.set_en        = do_split;
                cmd.set_idx       = rsp.spare_idx;
            end
            S_SPL_OLD:
            begin
                cmd.wr_en        = 1'b1;
                cmd.wr_idx       = tgt_idx_reg;
                cmd.wr_data      = tgt_rec_reg;
                cmd.wr_data.free = 1'b0;
            end
            S_REL_WR:
            begin
                cmd.wr_en        = 1'b1;
                cmd.wr_idx       = fidx_reg;
                cmd.wr_data      = frec_reg;
                cmd.wr_data.free = 1'b1;
            end
            S_MRG_RD0:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_idx = '0;
            end
            S_MRG_LD0:
            begin
                cmd.rd_en  = (d.link != '0);
                cmd.rd_idx = d.link;
            end
            S_MRG_CHK:
            begin
                cmd.rd_en             = (d.link != '0);
                cmd.rd_idx            = d.link;
                cmd.wr_en             = do_merge;
                cmd.wr_idx            = cur_idx_reg;
                cmd.wr_data           = cur_rec_reg;
                cmd.wr_data.size      = cur_rec_reg.size + OFF_W'(HEADER_BYTES) + d.size;
                cmd.wr_data.link      = d.link;
                cmd.clr_en            = do_merge;
                cmd.clr_idx           = nx_idx_reg;
            end
            S_DONE:
            begin
                result.done = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign result.res_off = res_reg;
    assign result.status  = status_reg;
    assign result.in_use  = cnt_reg;

    always_comb
    begin
        op_next         = op_reg;
        size_next       = size_reg;
        req_zero_next   = req_zero_reg;
        off_next        = off_reg;
        fidx_next       = fidx_reg;
        frec_next       = frec_reg;
        cur_idx_next    = cur_idx_reg;
        cur_rec_next    = cur_rec_reg;
        nx_idx_next     = nx_idx_reg;
        best_valid_next = best_valid_reg;
        best_idx_next   = best_idx_reg;
        best_rec_next   = best_rec_reg;
        tgt_idx_next    = tgt_idx_reg;
        tgt_rec_next    = tgt_rec_reg;
        alloc_next      = alloc_reg;
        grow_next       = grow_reg;
        split_next      = split_reg;
        cnt_next        = cnt_reg;
        res_next        = res_reg;
        status_next     = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = in_op;
                    size_next       = in_size;
                    req_zero_next   = (in_req == '0);
                    off_next        = in_off;
                    cur_idx_next    = '0;
                    best_valid_next = 1'b0;
                    alloc_next      = 1'b1;
                    grow_next       = 1'b0;
                    res_next        = '0;
                    status_next     = ST_OK;
                    if (in_req == '0 && (in_op == OP_ALLOC ||
                        (in_op == OP_RESIZE && in_off == '0)))
                    begin
                        status_next = ST_ZERO;
                    end
                end
            end
            S_FND_CHK:
            begin
                if (find_match)
                begin
                    fidx_next    = cur_idx_reg;
                    frec_next    = d;
                    tgt_idx_next = cur_idx_reg;
                    tgt_rec_next = d;
                    alloc_next   = 1'b0;
                    cur_idx_next = '0;
                    grow_next    = 1'b1;
                    if (op_reg == OP_RESIZE && req_zero_reg)
                    begin
                        status_next = ST_ZERO;
                    end
                    else if (op_reg == OP_RESIZE && size_reg > SZ_W'(d.size))
                    begin
                        alloc_next = 1'b1;
                    end
                end
                else if (find_last)
                begin
                    status_next = ST_INVALID;
                end
                else
                begin
                    cur_idx_next = cur_idx_reg + idx_t'(1);
                end
            end
            S_ALC_CHK:
            begin
                if (fit)
                begin
                    best_valid_next = 1'b1;
                    best_idx_next   = cur_idx_reg;
                    best_rec_next   = d;
                end
                if (walk_end)
                begin
                    tgt_idx_next = pick_idx;
                    tgt_rec_next = pick_rec;
                    if (!have_best)
                    begin
                        status_next = ST_NOMEM;
                    end
                end
                else
                begin
                    cur_idx_next = d.link;
                end
            end
            S_SPL_NEW:
            begin
                split_next = do_split;
                if (do_split)
                begin
                    tgt_rec_next.size = nsize;
                    tgt_rec_next.link = rsp.spare_idx;
                end
            end
            S_SPL_OLD:
            begin
                if (alloc_reg)
                begin
                    cnt_next = (cnt_sum > (CNT_W+1)'({CNT_W{1'b1}})) ?
                               {CNT_W{1'b1}} : cnt_sum[CNT_W-1:0];
                    res_next = tgt_rec_reg.start + OFF_W'(HEADER_BYTES);
                end
                else
                begin
                    if (split_reg)
                    begin
                        cnt_next = cnt_less;
                    end
                    res_next = off_reg;
                end
            end
            S_REL_WR:
            begin
                cnt_next = cnt_less;
            end
            S_MRG_LD0:
            begin
                cur_idx_next = '0;
                cur_rec_next = d;
                nx_idx_next  = d.link;
            end
            S_MRG_CHK:
            begin
                nx_idx_next = d.link;
                if (do_merge)
                begin
                    cur_rec_next.size = cur_rec_reg.size + OFF_W'(HEADER_BYTES) + d.size;
                    cur_rec_next.link = d.link;
                end
                else
                begin
                    cur_idx_next = nx_idx_reg;
                    cur_rec_next = d;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        size_reg       <= size_next;
        req_zero_reg   <= req_zero_next;
        off_reg        <= off_next;
        fidx_reg       <= fidx_next;
        frec_reg       <= frec_next;
        cur_idx_reg    <= cur_idx_next;
        cur_rec_reg    <= cur_rec_next;
        nx_idx_reg     <= nx_idx_next;
        best_valid_reg <= best_valid_next;
        best_idx_reg   <= best_idx_next;
        best_rec_reg   <= best_rec_next;
        tgt_idx_reg    <= tgt_idx_next;
        tgt_rec_reg    <= tgt_rec_next;
        alloc_reg      <= alloc_next;
        grow_reg       <= grow_next;
        split_reg      <= split_next;
        res_reg        <= res_next;
        status_reg     <= status_next;
    end

endmodule

@@ rtl/best_fit_heap_allocator.sv @@
// Top level of the best-fit heap allocator: stream ports, result register,
// block table and sequencer. Uses bfha_pkg, bfha_table and bfha_seq.
//
//   Channel  Direction  Contents of one item
//   s_*      in         opcode, request_bytes, payload_offset
//   m_*      out        result_offset, status, bytes_in_use
//
// The table lookup, the best-fit walk and the merge pass each read one
// table entry per cycle from a single memory port.
// s_tready is high only while the sequencer is idle; a finished result
// waits in the output register while the next item is taken.
// Reset leaves one free block that spans the arena and a zero in-use count.
module best_fit_heap_allocator
    import bfha_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // opcode, request_bytes, payload_offset, zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // result_offset, status, bytes_in_use, zero pad
);

    tbl_cmd_t          cmd;
    tbl_rsp_t          rsp;
    seq_out_t          result;
    logic              out_free;
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    bfha_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    bfha_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (op_t'(s_tdata[1:0])),
        .in_req   (s_tdata[33:2]),
        .in_off   (s_tdata[53:34]),
        .out_free (out_free),
        .result   (result),
        .cmd      (cmd),
        .rsp      (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (result.done)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.done)
        begin
            m_tdata_reg <= {5'b0, result.in_use, result.status, result.res_off};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the best-fit heap allocator: directed table plus random
// allocate/release/resize/no-op traffic, checked against a behavioral block-list predictor.
// Depends on bfha_pkg and best_fit_heap_allocator.
module testbench;
    import bfha_pkg::*;

    localparam int NUM_RANDOM = 900;
    localparam int IN_MAX = 21'h1FFFFF;

    typedef struct {
        op_t         op;
        logic [31:0] req;
        logic [19:0] off;
        logic        known;
        logic [19:0] x_off;
        status_t     x_st;
        logic [20:0] x_cnt;
    } row_t;

    typedef struct {
        logic [19:0] off;
        status_t     st;
        logic [20:0] cnt;
    } grant_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    longint blk_start [MAX_BLOCKS];
    longint blk_size [MAX_BLOCKS];
    bit     blk_free [MAX_BLOCKS];
    int     blk_link [MAX_BLOCKS];
    bit     blk_valid [MAX_BLOCKS];
    longint used_bytes;

    grant_t pending_grants[$];
    logic [19:0] live_offsets[$];
    row_t directed[$];
    int mismatches = 0;
    int results_seen = 0;
    bit calm = 1'b0;

    best_fit_heap_allocator i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #4 clk = ~clk;

    function automatic int link_of(int i);
        return blk_link[i];
    endfunction

    function automatic bit cut_tail(int i, longint size);
        longint rem;
        int s;
        if (blk_size[i] < size) return 0;
        rem = blk_size[i] - size;
        if (rem < HEADER_BYTES + MIN_SPLIT_BYTES) return 0;
        for (s = 1; s < MAX_BLOCKS; s++) if (!blk_valid[s]) break;
        if (s >= MAX_BLOCKS) return 0;
        blk_start[s] = blk_start[i] + HEADER_BYTES + size;
        blk_size[s] = rem - HEADER_BYTES;
        blk_free[s] = 1;
        blk_link[s] = link_of(i);
        blk_valid[s] = 1;
        blk_size[i] = size;
        blk_link[i] = s;
        return 1;
    endfunction

    function automatic void merge_runs();
        int cur;
        int nx;
        cur = 0;
        for (int k = 0; k < 2 * MAX_BLOCKS; k++) begin
            nx = link_of(cur);
            if (nx == 0) break;
            if (blk_free[cur] && blk_free[nx]
                && blk_start[cur] + HEADER_BYTES + blk_size[cur] == blk_start[nx]) begin
                blk_size[cur] += HEADER_BYTES + blk_size[nx];
                blk_link[cur] = link_of(nx);
                blk_valid[nx] = 0;
                blk_free[nx] = 0;
                blk_link[nx] = 0;
                blk_start[nx] = 0;
                blk_size[nx] = 0;
            end else begin
                cur = nx;
            end
        end
    endfunction

    function automatic int find_block(longint off);
        for (int i = 0; i < MAX_BLOCKS; i++)
            if (blk_valid[i] && !blk_free[i] && blk_start[i] + HEADER_BYTES == off) return i;
        return MAX_BLOCKS;
    endfunction

    function automatic status_t carve(longint req, output longint off);
        longint size;
        longint best_bytes;
        int cur;
        int best;
        bit dummy;
        off = 0;
        if (req == 0) return ST_ZERO;
        size = ((req + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        cur = 0;
        best = MAX_BLOCKS;
        best_bytes = 0;
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            if (blk_free[cur] && blk_size[cur] >= size
                && (best == MAX_BLOCKS || blk_size[cur] < best_bytes)) begin
                best = cur;
                best_bytes = blk_size[cur];
                if (best_bytes == size) break;
            end
            cur = link_of(cur);
            if (cur == 0) break;
        end
        if (best == MAX_BLOCKS) return ST_NOMEM;
        dummy = cut_tail(best, size);
        blk_free[best] = 0;
        used_bytes += size;
        if (used_bytes > IN_MAX) used_bytes = IN_MAX;
        off = blk_start[best] + HEADER_BYTES;
        return ST_OK;
    endfunction

    function automatic void give_back(int i);
        blk_free[i] = 1;
        used_bytes = (blk_size[i] >= used_bytes) ? 0 : used_bytes - blk_size[i];
        merge_runs();
    endfunction

    function automatic void heap_reset();
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            blk_start[i] = 0; blk_size[i] = 0; blk_free[i] = 0;
            blk_link[i] = 0; blk_valid[i] = 0;
        end
        blk_start[0] = POOL_HEADER_BYTES;
        blk_size[0] = ARENA_BYTES - POOL_HEADER_BYTES - HEADER_BYTES;
        blk_free[0] = 1;
        blk_valid[0] = 1;
        used_bytes = 0;
    endfunction

    function automatic grant_t heap_step(op_t op, logic [31:0] req, logic [19:0] off);
        grant_t g;
        longint res;
        longint size;
        longint old;
        int idx;
        res = 0;
        g.st = ST_OK;
        if (op == OP_ALLOC) begin
            g.st = carve(req, res);
        end else if (op == OP_RELEASE) begin
            if (off != 0) begin
                idx = find_block(off);
                if (idx == MAX_BLOCKS) g.st = ST_INVALID;
                else give_back(idx);
            end
        end else if (op == OP_RESIZE) begin
            if (off == 0) begin
                g.st = carve(req, res);
            end else begin
                idx = find_block(off);
                if (idx == MAX_BLOCKS) begin
                    g.st = ST_INVALID;
                end else if (req == 0) begin
                    give_back(idx);
                    g.st = ST_ZERO;
                end else begin
                    size = ((longint'(req) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
                    old = blk_size[idx];
                    if (size <= old) begin
                        if (cut_tail(idx, size))
                            used_bytes = (old - size >= used_bytes) ? 0 : used_bytes - (old - size);
                        res = off;
                    end else begin
                        g.st = carve(size, res);
                        if (g.st == ST_OK) give_back(idx);
                    end
                end
            end
        end
        g.off = res[19:0];
        g.cnt = used_bytes[20:0];
        return g;
    endfunction

    function automatic void add_row(op_t op, logic [31:0] req, logic [19:0] off, logic known,
                                    logic [19:0] xo, status_t xs, logic [20:0] xc);
        row_t r;
        r.op = op; r.req = req; r.off = off; r.known = known;
        r.x_off = xo; r.x_st = xs; r.x_cnt = xc;
        directed.push_back(r);
    endfunction

    task automatic send_item(op_t op, logic [31:0] req, logic [19:0] off, logic known,
                             grant_t typed);
        grant_t g;
        if (!calm)
            while ($urandom_range(99) < 20)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        s_tdata <= {2'b00, off, req, op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        g = heap_step(op, req, off);
        if (known && (g.off != typed.off || g.st != typed.st || g.cnt != typed.cnt))
            $display("directed row disagrees with predictor: op %0d req %0d", op, req);
        if (known) g = typed;
        pending_grants.push_back(g);
        if (g.st == ST_OK && g.off != 0 && op != OP_RELEASE) live_offsets.push_back(g.off);
        @(negedge clk);
    endtask

    always @(negedge clk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 20);
    end

    always @(posedge clk) begin
        grant_t want;
        if (rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_grants.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = pending_grants.pop_front();
                if (m_tdata[19:0] != want.off || m_tdata[21:20] != want.st
                    || m_tdata[42:22] != want.cnt || m_tdata[47:43] != '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected off %h st %0d cnt %0d, got off %h st %0d cnt %0d",
                                 want.off, want.st, want.cnt,
                                 m_tdata[19:0], m_tdata[21:20], m_tdata[42:22]);
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        grant_t typed;
        op_t op;
        logic [31:0] req;
        logic [19:0] off;
        int pick;
        int guard;
        heap_reset();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows, the first ones with a typed result: first grant sits after pool and block headers.
        add_row(OP_ALLOC, 32'd0, 20'd0, 1, 20'd0, ST_ZERO, 21'd0);
        add_row(OP_RELEASE, 32'd0, 20'd0, 1, 20'd0, ST_OK, 21'd0);
        add_row(OP_RELEASE, 32'd0, 20'hFFFFF, 1, 20'd0, ST_INVALID, 21'd0);
        add_row(OP_RESIZE, 32'd5, 20'd100, 1, 20'd0, ST_INVALID, 21'd0);
        add_row(OP_NOP, 32'hFFFFFFFF, 20'hFFFFF, 1, 20'd0, ST_OK, 21'd0);
        add_row(OP_ALLOC, 32'hFFFFFFFF, 20'd0, 1, 20'd0, ST_NOMEM, 21'd0);
        add_row(OP_ALLOC, 32'd1, 20'd0, 1, 20'd48, ST_OK, 21'd8);
        add_row(OP_RELEASE, 32'd0, 20'd48, 1, 20'd0, ST_OK, 21'd0);
        add_row(OP_ALLOC, 32'd1048528, 20'd0, 1, 20'd48, ST_OK, 21'd1048528);
        add_row(OP_ALLOC, 32'd8, 20'd0, 1, 20'd0, ST_NOMEM, 21'd1048528);
        add_row(OP_RELEASE, 32'd0, 20'd48, 1, 20'd0, ST_OK, 21'd0);
        add_row(OP_ALLOC, 32'd100, 20'd0, 0, 0, ST_OK, 0);
        add_row(OP_ALLOC, 32'd200, 20'd0, 0, 0, ST_OK, 0);
        add_row(OP_RESIZE, 32'd16, 20'd48, 0, 0, ST_OK, 0);
        add_row(OP_RESIZE, 32'd4000, 20'd48, 0, 0, ST_OK, 0);
        add_row(OP_RESIZE, 32'hFFFFFFF0, 20'd176, 0, 0, ST_OK, 0);
        add_row(OP_RESIZE, 32'd0, 20'd176, 0, 0, ST_OK, 0);
        add_row(OP_RESIZE, 32'd64, 20'd0, 0, 0, ST_OK, 0);
        add_row(OP_RESIZE, 32'd9, 20'd0, 0, 0, ST_OK, 0);
        add_row(OP_RELEASE, 32'hFFFFFFFF, 20'd49, 0, 0, ST_OK, 0);
        foreach (directed[i]) begin
            typed.off = directed[i].x_off;
            typed.st = directed[i].x_st;
            typed.cnt = directed[i].x_cnt;
            send_item(directed[i].op, directed[i].req, directed[i].off, directed[i].known, typed);
        end

        typed = '{off: 0, st: ST_OK, cnt: 0};
        for (int n = 0; n < NUM_RANDOM; n++) begin
            calm = (n >= 300 && n < 400);
            pick = $urandom_range(99);
            req = ($urandom_range(9) == 0) ? $urandom : $urandom_range(4096);
            if ($urandom_range(19) == 0) req = $urandom_range(1) ? 32'd0 : 32'd1048528;
            off = 0;
            if (pick < 45) begin
                op = OP_ALLOC;
                off = 20'($urandom);
            end else if (pick < 80 && live_offsets.size() > 0) begin
                op = (pick < 68) ? OP_RELEASE : OP_RESIZE;
                pick = $urandom_range(live_offsets.size() - 1);
                off = live_offsets[pick];
                live_offsets.delete(pick);
            end else if (pick < 90) begin
                op = $urandom_range(1) ? OP_RELEASE : OP_RESIZE;
                off = 20'($urandom);
            end else begin
                op = op_t'($urandom_range(3));
                off = ($urandom_range(1)) ? 20'd0 : 20'($urandom);
            end
            send_item(op, req, off, 0, typed);
        end
        s_tvalid <= 1'b0;

        calm = 1'b0;
        guard = 0;
        while (pending_grants.size() > 0 && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (3 * MAX_BLOCKS + 20) @(posedge clk);
        $display("Ran %0d directed and %0d random items, %0d results checked, %0d mismatches.",
                 directed.size(), NUM_RANDOM, results_seen, mismatches);
        if (mismatches == 0 && pending_grants.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/bfha_pkg.sv
rtl/bfha_table.sv
rtl/bfha_seq.sv
rtl/best_fit_heap_allocator.sv
bench/testbench.sv
